[hdl/atan2_poly_octant_core_defines.svh]
// assertion macros shared by the atan2 octant core
`ifndef ATAN2_POLY_OCTANT_CORE_DEFINES_SVH
`define ATAN2_POLY_OCTANT_CORE_DEFINES_SVH

// plain invariant, sampled on clk, quiet during reset
`define A2PO_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// same-cycle implication, sampled on clk, quiet during reset
`define A2PO_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

[hdl/atan2po_pkg.sv]
// types and constants of the atan2 octant core
`timescale 1ns / 1ps

package atan2po_pkg;

    // width of the ratio and of the polynomial datapath (Q0.16)
    localparam int QBITS      = 16;
    localparam int ANGLE_BITS = 16;

    // polynomial coefficients scaled by 2^16
    localparam logic [11:0] COEF_C = 12'd3047;
    localparam logic [13:0] COEF_B = 14'd10441;
    localparam logic [14:0] COEF_A = 15'd21471;

    // Q3.13 angles
    localparam logic [13:0] HALF_PI_Q13 = 14'd12868;
    localparam logic [14:0] PI_Q13      = 15'd25736;

    // rounding offset for Q0.16 to Q3.13
    localparam logic [16:0] ROUND_Q13 = 17'd4;

    // octant and special case flags that travel with an item
    typedef struct packed {
        logic gt;    // |y| > |x|
        logic eq;    // |y| == |x|
        logic zero;  // both components zero
        logic xneg;
        logic yneg;
    } flags_t;

endpackage

[hdl/atan2po_in_if.sv]
// input channel: sine and cosine components
`timescale 1ns / 1ps

interface atan2po_in_if #(
    parameter int INPUT_BITS = 16
);
    logic                         valid;
    logic                         ready;
    logic signed [INPUT_BITS-1:0] sin_component;
    logic signed [INPUT_BITS-1:0] cos_component;

    modport source (output valid, sin_component, cos_component, input ready);
    modport sink   (input valid, sin_component, cos_component, output ready);
endinterface

[hdl/atan2po_out_if.sv]
// output channel: angle and undefined flag
`timescale 1ns / 1ps

interface atan2po_out_if;
    import atan2po_pkg::*;

    logic                         valid;
    logic                         ready;
    logic signed [ANGLE_BITS-1:0] angle;
    logic                         undefined_angle;

    modport source (output valid, angle, undefined_angle, input ready);
    modport sink   (input valid, angle, undefined_angle, output ready);
endinterface

[hdl/atan2_poly_octant_core.sv]
// top level of the atan2 octant core: magnitudes, divider, polynomial, folding
`timescale 1ns / 1ps
`include "atan2_poly_octant_core_defines.svh"

// Four-quadrant arctangent of a signed (sine, cosine) pair. The smaller magnitude is
// divided by the larger to give a Q0.16 ratio, an odd 7th-order polynomial turns it
// into the first-octant angle, and the signs and relative size of the components fold
// it out to a signed Q3.13 angle in -pi..pi. Both components zero gives angle 0 with
// undefined_angle set. The core takes one transfer per clock while the result side does not stall.
// An item passes through magnitudes and ordering, then the divider, which resolves
// one quotient bit per stage, then the polynomial (one multiply per stage), and last
// rounding and folding. Each stage holds its item only while the stage after it is
// full and stalled, so bubbles close up behind a waiting result and input is taken as
// long as any stage can move.
module atan2_poly_octant_core #(
    parameter int INPUT_BITS = 16
) (
    input logic            clk,
    input logic            rst_n,
    atan2po_in_if.sink     vec,
    atan2po_out_if.source  res
);
    import atan2po_pkg::*;

    // valid bits: 0 magnitudes, 1 ordering, 2..6 polynomial, 7 round and pi/2 fold
    logic vld_reg [8];
    logic ld      [9];
    logic out_vld_reg;

    logic div_up_ready;
    logic div_vld;
    logic [QBITS-1:0] div_quo;
    flags_t div_side;

    // stage 0: magnitudes and signs
    logic [INPUT_BITS-1:0] ay_next, ax_next;
    logic [INPUT_BITS-1:0] s0_ay_reg, s0_ax_reg;
    logic                  s0_yneg_reg, s0_xneg_reg;

    assign ay_next = vec.sin_component[INPUT_BITS-1] ?
                     INPUT_BITS'(~vec.sin_component + 1'b1) : vec.sin_component;
    assign ax_next = vec.cos_component[INPUT_BITS-1] ?
                     INPUT_BITS'(~vec.cos_component + 1'b1) : vec.cos_component;

    // stage 1: order the magnitudes
    logic [INPUT_BITS-1:0] s1_mn_reg, s1_mx_reg;
    flags_t                s1_side_reg;
    flags_t                side_next;

    always_comb
    begin
        side_next.gt   = s0_ay_reg > s0_ax_reg;
        side_next.eq   = s0_ay_reg == s0_ax_reg;
        side_next.zero = (s0_ay_reg == '0) && (s0_ax_reg == '0);
        side_next.xneg = s0_xneg_reg;
        side_next.yneg = s0_yneg_reg;
    end

    // stage 2: ratio (a 1.0 ratio saturates) and s = a*a
    logic [QBITS-1:0]   a_next;
    logic [2*QBITS-1:0] sq;
    logic [QBITS-1:0]   s2_a_reg, s2_s_reg;
    flags_t             s2_side_reg;

    assign a_next = div_side.eq ? {QBITS{1'b1}} : div_quo;
    assign sq     = a_next * a_next;

    // stage 3: p = (B - C*s) >> 16
    logic [29:0]      tp;
    logic [QBITS-1:0] s3_a_reg, s3_s_reg;
    logic [13:0]      s3_p_reg;
    flags_t           s3_side_reg;

    assign tp = {COEF_B, 16'h0000} - (30'(COEF_C) * 30'(s2_s_reg));

    // stage 4: q = (A - p*s) >> 16
    logic [29:0]      ps;
    logic [30:0]      tq;
    logic [QBITS-1:0] s4_a_reg, s4_s_reg;
    logic [14:0]      s4_q_reg;
    flags_t           s4_side_reg;

    assign ps = s3_p_reg * s3_s_reg;
    assign tq = {COEF_A, 16'h0000} - 31'(ps);

    // stage 5: u = (q*s) >> 16
    logic [30:0]      qs;
    logic [QBITS-1:0] s5_a_reg;
    logic [14:0]      s5_u_reg;
    flags_t           s5_side_reg;

    assign qs = s4_q_reg * s4_s_reg;

    // stage 6: r = a - (u*a) >> 16
    logic [30:0]      ua;
    logic [QBITS-1:0] s6_r_reg;
    flags_t           s6_side_reg;

    assign ua = s5_u_reg * s5_a_reg;

    // stage 7: round to Q3.13, pi/2 fold
    logic [16:0] rs;
    logic [13:0] r13;
    logic [13:0] h_next;
    logic [13:0] s7_h_reg;
    flags_t      s7_side_reg;

    assign rs     = 17'(s6_r_reg) + ROUND_Q13;
    assign r13    = rs[16:3];
    assign h_next = s6_side_reg.gt ? (HALF_PI_Q13 - r13) : r13;

    // output stage: pi fold, sign, zero case
    logic [14:0]                  f;
    logic signed [ANGLE_BITS-1:0] fs;
    logic signed [ANGLE_BITS-1:0] angle_next;
    logic signed [ANGLE_BITS-1:0] angle_reg;
    logic                         undef_reg;

    always_comb
    begin
        f  = s7_side_reg.xneg ? (PI_Q13 - 15'(s7_h_reg)) : 15'(s7_h_reg);
        fs = signed'({1'b0, f});
        if (s7_side_reg.zero)
        begin
            angle_next = '0;
        end
        else if (s7_side_reg.yneg)
        begin
            angle_next = -fs;
        end
        else
        begin
            angle_next = fs;
        end
    end

    // stall chain: a stage loads when empty or when it is handing on
    assign ld[8] = ~out_vld_reg | res.ready;
    for (genvar k = 2; k < 8; k++) begin : g_ld
        assign ld[k] = ~vld_reg[k] | ld[k+1];
    end
    assign ld[1] = ~vld_reg[1] | div_up_ready;
    assign ld[0] = ~vld_reg[0] | ld[1];

    assign vec.ready = ld[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (ld[0]) vld_reg[0] <= vec.valid;
            if (ld[1]) vld_reg[1] <= vld_reg[0];
            if (ld[2]) vld_reg[2] <= div_vld;
            for (int i = 3; i < 8; i++)
            begin
                if (ld[i]) vld_reg[i] <= vld_reg[i-1];
            end
            if (ld[8]) out_vld_reg <= vld_reg[7];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld[0] && vec.valid)
        begin
            s0_ay_reg   <= ay_next;
            s0_ax_reg   <= ax_next;
            s0_yneg_reg <= vec.sin_component[INPUT_BITS-1];
            s0_xneg_reg <= vec.cos_component[INPUT_BITS-1];
        end
        if (ld[1] && vld_reg[0])
        begin
            s1_mn_reg   <= side_next.gt ? s0_ax_reg : s0_ay_reg;
            s1_mx_reg   <= side_next.gt ? s0_ay_reg : s0_ax_reg;
            s1_side_reg <= side_next;
        end
        if (ld[2] && div_vld)
        begin
            s2_a_reg    <= a_next;
            s2_s_reg    <= sq[2*QBITS-1:QBITS];
            s2_side_reg <= div_side;
        end
        if (ld[3] && vld_reg[2])
        begin
            s3_a_reg    <= s2_a_reg;
            s3_s_reg    <= s2_s_reg;
            s3_p_reg    <= tp[29:16];
            s3_side_reg <= s2_side_reg;
        end
        if (ld[4] && vld_reg[3])
        begin
            s4_a_reg    <= s3_a_reg;
            s4_s_reg    <= s3_s_reg;
            s4_q_reg    <= tq[30:16];
            s4_side_reg <= s3_side_reg;
        end
        if (ld[5] && vld_reg[4])
        begin
            s5_a_reg    <= s4_a_reg;
            s5_u_reg    <= qs[30:16];
            s5_side_reg <= s4_side_reg;
        end
        if (ld[6] && vld_reg[5])
        begin
            s6_r_reg    <= s5_a_reg - QBITS'(ua[30:16]);
            s6_side_reg <= s5_side_reg;
        end
        if (ld[7] && vld_reg[6])
        begin
            s7_h_reg    <= h_next;
            s7_side_reg <= s6_side_reg;
        end
        if (ld[8] && vld_reg[7])
        begin
            angle_reg <= angle_next;
            undef_reg <= s7_side_reg.zero;
        end
    end

    atan2po_div #(
        .INPUT_BITS (INPUT_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (vld_reg[1]),
        .up_ready (div_up_ready),
        .mn       (s1_mn_reg),
        .mx       (s1_mx_reg),
        .side     (s1_side_reg),
        .dn_valid (div_vld),
        .dn_ready (ld[2]),
        .quo      (div_quo),
        .dn_side  (div_side)
    );

    assign res.valid           = out_vld_reg;
    assign res.angle           = angle_reg;
    assign res.undefined_angle = undef_reg;

    // terms checked below
    logic undef_out;
    logic angle_in_range;
    logic flags_ok;

    assign undef_out      = res.valid && res.undefined_angle;
    assign angle_in_range = (res.angle <= 16'sd25736) && (res.angle >= -16'sd25736);
    assign flags_ok       = !(s1_side_reg.gt && s1_side_reg.eq)
                            && (!s1_side_reg.zero || s1_side_reg.eq);

    `A2PO_ASSERT_IMP(a_undef_zero, undef_out, res.angle == '0, "undefined angle not zero")
    `A2PO_ASSERT_IMP(a_angle_range, res.valid, angle_in_range, "angle outside -pi..pi")
    `A2PO_ASSERT_IMP(a_order_flags, vld_reg[1], flags_ok, "inconsistent octant flags")
    `A2PO_ASSERT_IMP(a_fold_range, vld_reg[7], s7_h_reg <= HALF_PI_Q13, "fold above pi/2")

endmodule

[hdl/atan2po_div.sv]
// pipelined restoring divider, one quotient bit per stage
`timescale 1ns / 1ps

module atan2po_div #(
    parameter int INPUT_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          up_valid,
    output logic                          up_ready,
    input  logic [INPUT_BITS-1:0]         mn,
    input  logic [INPUT_BITS-1:0]         mx,
    input  atan2po_pkg::flags_t           side,
    output logic                          dn_valid,
    input  logic                          dn_ready,
    output logic [atan2po_pkg::QBITS-1:0] quo,
    output atan2po_pkg::flags_t           dn_side
);
    import atan2po_pkg::*;

    localparam int NST = QBITS;

    // stage inputs: index 0 is the upstream side, index g+1 is register g
    logic [INPUT_BITS-1:0] rem_s  [NST+1];
    logic [INPUT_BITS-1:0] div_s  [NST+1];
    logic [QBITS-1:0]      quo_s  [NST+1];
    flags_t                side_s [NST+1];
    logic                  vld_s  [NST+1];
    logic                  ld     [NST+1];

    logic [INPUT_BITS-1:0] rem_reg  [NST];
    logic [INPUT_BITS-1:0] div_reg  [NST];
    logic [QBITS-1:0]      quo_reg  [NST];
    flags_t                side_reg [NST];
    logic                  vld_reg  [NST];

    assign rem_s[0]  = mn;
    assign div_s[0]  = mx;
    assign quo_s[0]  = '0;
    assign side_s[0] = side;
    assign vld_s[0]  = up_valid;
    assign ld[NST]   = dn_ready;

    for (genvar g = 0; g < NST; g++) begin : g_stage
        logic [INPUT_BITS:0]   dbl;
        logic [INPUT_BITS+1:0] diff;
        logic                  ge;
        logic [INPUT_BITS-1:0] rem_next;
        logic [QBITS-1:0]      quo_next;

        // remainder never exceeds the divisor, so the doubled value fits one extra bit
        assign dbl      = {rem_s[g], 1'b0};
        assign diff     = {1'b0, dbl} - {2'b00, div_s[g]};
        assign ge       = ~diff[INPUT_BITS+1];
        assign rem_next = ge ? diff[INPUT_BITS-1:0] : dbl[INPUT_BITS-1:0];
        assign quo_next = {quo_s[g][QBITS-2:0], ge};

        // a stage takes new data when empty or when its contents move on
        assign ld[g] = ~vld_reg[g] | ld[g+1];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[g] <= 1'b0;
            end
            else if (ld[g])
            begin
                vld_reg[g] <= vld_s[g];
            end
        end

        always_ff @(posedge clk)
        begin
            if (ld[g] && vld_s[g])
            begin
                rem_reg[g]  <= rem_next;
                div_reg[g]  <= div_s[g];
                quo_reg[g]  <= quo_next;
                side_reg[g] <= side_s[g];
            end
        end

        assign rem_s[g+1]  = rem_reg[g];
        assign div_s[g+1]  = div_reg[g];
        assign quo_s[g+1]  = quo_reg[g];
        assign side_s[g+1] = side_reg[g];
        assign vld_s[g+1]  = vld_reg[g];
    end

    assign up_ready = ld[0];
    assign dn_valid = vld_reg[NST-1];
    assign quo      = quo_reg[NST-1];
    assign dn_side  = side_reg[NST-1];

endmodule
